// File: rtl/rpf1_pkg.sv
// rpf1_pkg: shared constants, step codes and divider status type for the
// rule pair f1 scorer; used by rpf1_div and rule_pair_f1_scorer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpf1_pkg;

    localparam int              LANES_DEF       = 64;
    localparam longint unsigned MAX_SAMPLES_DEF = 64'd1048576;

    localparam int LANE_CNT_W = 7;
    localparam int SCORE_W    = 17;
    localparam int SAMPLES_W  = 21;
    localparam int FRAC_W     = 16;
    localparam int QUO_W      = 17;
    localparam int CHUNK_W    = 8;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;

    typedef logic [2:0] step_t;

    localparam step_t STEP_AND_TP = 3'd0;
    localparam step_t STEP_AND_FP = 3'd1;
    localparam step_t STEP_AND_FN = 3'd2;
    localparam step_t STEP_OR_TP  = 3'd3;
    localparam step_t STEP_OR_FP  = 3'd4;
    localparam step_t STEP_OR_FN  = 3'd5;
    localparam step_t STEP_TOTAL  = 3'd6;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/rpf1_div.sv
// rpf1_div: radix-2 restoring divider, one quotient bit per cycle,
// QUO_W quotient bits; a zero divisor gives a zero quotient
// depends on rpf1_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpf1_div #(
    parameter int DEN_W = 23
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     start,
    input  wire logic [DEN_W+rpf1_pkg::QUO_W-1:0]         dividend,
    input  wire logic [DEN_W-1:0]                         divisor,
    output rpf1_pkg::div_stat_t                           stat,
    output logic      [rpf1_pkg::QUO_W-1:0]               quotient
);

    localparam int QW = rpf1_pkg::QUO_W;
    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb begin
        trial    = {rem_reg, quo_reg[QW-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next = {quo_reg[QW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (divisor == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(QW);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[DEN_W+QW-1:QW];
            quo_reg <= (divisor == '0) ? '0 : dividend[QW-1:0];
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// File: rtl/rule_pair_f1_scorer.sv
// rule_pair_f1_scorer: top level, input capture, shared popcount and
// saturating accumulator, sequencer and result register
// depends on rpf1_pkg and rpf1_div
//
// Each input transaction carries up to LANES samples (two rule bits and a
// label bit per lane) and is counted into six saturating true positive,
// false positive and false negative counters for the AND and the OR of the
// two rules, plus a sample counter. One shared 8-bit popcount and saturating
// adder walks the counters one lane chunk per cycle, and s_ready is low while
// a transaction is in progress. On a transaction marked last, one shared
// radix-2 divider computes both F1 scores, 2tp/(2tp+fp+fn) in Q1.16 rounded
// half up, one after the other; the result then waits in an output register
// and the counters clear. A new input transaction is taken while a result
// still waits for m_ready.
`timescale 1ns / 1ps
`default_nettype none

module rule_pair_f1_scorer #(
    parameter int              LANES       = rpf1_pkg::LANES_DEF,
    parameter longint unsigned MAX_SAMPLES = rpf1_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [LANES-1:0]                    s_rule_a_bits,
    input  wire logic [LANES-1:0]                    s_rule_b_bits,
    input  wire logic [LANES-1:0]                    s_label_bits,
    input  wire logic [rpf1_pkg::LANE_CNT_W-1:0]     s_lane_count,
    input  wire logic                                s_last_item,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [rpf1_pkg::SCORE_W-1:0]        m_and_score,
    output logic      [rpf1_pkg::SCORE_W-1:0]        m_or_score,
    output logic      [rpf1_pkg::SAMPLES_W-1:0]      m_samples_seen
);

    localparam int LCW     = rpf1_pkg::LANE_CNT_W;
    localparam int CHW     = rpf1_pkg::CHUNK_W;
    localparam int QW      = rpf1_pkg::QUO_W;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int DEN_W   = CNT_W + 2;
    localparam int DIV_W   = DEN_W + QW;
    localparam int NCHUNK  = (LANES + CHW - 1) / CHW;
    localparam int PAD_W   = NCHUNK * CHW;
    localparam int CH_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int POP_W   = $clog2(CHW + 1);
    localparam int LN_W    = $clog2(LANES + 1);
    localparam int INC_W   = (POP_W > LN_W) ? POP_W : LN_W;
    localparam logic [CNT_W:0] MAX_SUM = (CNT_W + 1)'(MAX_SAMPLES);
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NCHUNK - 1);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_ACC       = 7'b0000010,
        S_AND_START = 7'b0000100,
        S_AND_WAIT  = 7'b0001000,
        S_OR_START  = 7'b0010000,
        S_OR_WAIT   = 7'b0100000,
        S_OUT       = 7'b1000000
    } state_t;

    function automatic logic [POP_W-1:0] pop8(input logic [CHW-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < CHW; i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

    state_t                state_reg;
    rpf1_pkg::step_t       step_reg;
    logic [CH_W-1:0]       chunk_reg;
    logic                  m_valid_reg;

    logic [LANES-1:0]      pand_reg, por_reg, lab_reg;
    logic [LN_W-1:0]       lanes_reg;
    logic                  last_reg;

    logic [CNT_W-1:0]      and_tp_reg, and_fp_reg, and_fn_reg;
    logic [CNT_W-1:0]      or_tp_reg, or_fp_reg, or_fn_reg;
    logic [CNT_W-1:0]      total_reg;

    logic [QW-1:0]         and_score_reg, or_score_reg;
    logic [rpf1_pkg::SCORE_W-1:0]   m_and_score_reg, m_or_score_reg;
    logic [rpf1_pkg::SAMPLES_W-1:0] m_samples_reg;

    logic [LCW-1:0]        lanes_clamp;
    logic [LANES-1:0]      lane_mask;
    logic                  in_accept;
    logic                  out_load;

    logic [LANES-1:0]      word_sel;
    logic [PAD_W-1:0]      word_pad;
    logic [CHW-1:0]        chunk_bits;
    logic [INC_W-1:0]      inc;
    logic [CNT_W-1:0]      acc_cur;
    logic [CNT_W:0]        sum;
    logic [CNT_W-1:0]      sat;

    logic                  div_start;
    logic                  sel_or;
    logic [CNT_W-1:0]      op_tp, op_fp, op_fn;
    logic [DEN_W-1:0]      den;
    logic [DIV_W-1:0]      dividend;
    rpf1_pkg::div_stat_t   div_stat;
    logic [QW-1:0]         quotient;

    // input capture
    assign s_ready   = (state_reg == S_IDLE);
    assign in_accept = s_valid && s_ready;

    always_comb begin
        lanes_clamp = (s_lane_count > LCW'(LANES)) ? LCW'(LANES) : s_lane_count;
        for (int i = 0; i < LANES; i++) begin
            lane_mask[i] = (lanes_clamp > LCW'(i));
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pand_reg  <= s_rule_a_bits & s_rule_b_bits & lane_mask;
            por_reg   <= (s_rule_a_bits | s_rule_b_bits) & lane_mask;
            lab_reg   <= s_label_bits & lane_mask;
            lanes_reg <= LN_W'(lanes_clamp);
            last_reg  <= s_last_item;
        end
    end

    // shared popcount and saturating adder
    always_comb begin
        unique case (step_reg)
            rpf1_pkg::STEP_AND_TP: begin
                word_sel = pand_reg & lab_reg;
                acc_cur  = and_tp_reg;
            end
            rpf1_pkg::STEP_AND_FP: begin
                word_sel = pand_reg & ~lab_reg;
                acc_cur  = and_fp_reg;
            end
            rpf1_pkg::STEP_AND_FN: begin
                word_sel = ~pand_reg & lab_reg;
                acc_cur  = and_fn_reg;
            end
            rpf1_pkg::STEP_OR_TP: begin
                word_sel = por_reg & lab_reg;
                acc_cur  = or_tp_reg;
            end
            rpf1_pkg::STEP_OR_FP: begin
                word_sel = por_reg & ~lab_reg;
                acc_cur  = or_fp_reg;
            end
            rpf1_pkg::STEP_OR_FN: begin
                word_sel = ~por_reg & lab_reg;
                acc_cur  = or_fn_reg;
            end
            rpf1_pkg::STEP_TOTAL: begin
                word_sel = '0;
                acc_cur  = total_reg;
            end
            default: begin
                word_sel = '0;
                acc_cur  = '0;
            end
        endcase
        word_pad   = PAD_W'(word_sel);
        chunk_bits = word_pad[chunk_reg * CHW +: CHW];
        inc        = (step_reg == rpf1_pkg::STEP_TOTAL) ? INC_W'(lanes_reg)
                                                        : INC_W'(pop8(chunk_bits));
        sum        = (CNT_W + 1)'(acc_cur) + (CNT_W + 1)'(inc);
        sat        = (sum > MAX_SUM) ? MAX_SUM[CNT_W-1:0] : sum[CNT_W-1:0];
    end

    // divider operands
    always_comb begin
        sel_or    = (state_reg == S_OR_START);
        div_start = (state_reg == S_AND_START) || (state_reg == S_OR_START);
        op_tp     = sel_or ? or_tp_reg : and_tp_reg;
        op_fp     = sel_or ? or_fp_reg : and_fp_reg;
        op_fn     = sel_or ? or_fn_reg : and_fn_reg;
        den       = DEN_W'({op_tp, 1'b0}) + DEN_W'(op_fp) + DEN_W'(op_fn);
        dividend  = DIV_W'({op_tp, 1'b0, {rpf1_pkg::FRAC_W{1'b0}}})
                  + DIV_W'(den >> 1);
    end

    rpf1_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // sequencer and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= rpf1_pkg::STEP_AND_TP;
            chunk_reg   <= '0;
            m_valid_reg <= 1'b0;
            and_tp_reg  <= '0;
            and_fp_reg  <= '0;
            and_fn_reg  <= '0;
            or_tp_reg   <= '0;
            or_fp_reg   <= '0;
            or_fn_reg   <= '0;
            total_reg   <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_ACC;
                        step_reg  <= rpf1_pkg::STEP_AND_TP;
                        chunk_reg <= '0;
                    end
                end
                S_ACC: begin
                    unique case (step_reg)
                        rpf1_pkg::STEP_AND_TP: and_tp_reg <= sat;
                        rpf1_pkg::STEP_AND_FP: and_fp_reg <= sat;
                        rpf1_pkg::STEP_AND_FN: and_fn_reg <= sat;
                        rpf1_pkg::STEP_OR_TP:  or_tp_reg  <= sat;
                        rpf1_pkg::STEP_OR_FP:  or_fp_reg  <= sat;
                        rpf1_pkg::STEP_OR_FN:  or_fn_reg  <= sat;
                        rpf1_pkg::STEP_TOTAL:  total_reg  <= sat;
                        default: ;
                    endcase
                    if (step_reg == rpf1_pkg::STEP_TOTAL) begin
                        state_reg <= last_reg ? S_AND_START : S_IDLE;
                    end else if (chunk_reg == LAST_CH) begin
                        chunk_reg <= '0;
                        step_reg  <= rpf1_pkg::step_t'(step_reg + 3'd1);
                    end else begin
                        chunk_reg <= chunk_reg + CH_W'(1);
                    end
                end
                S_AND_START: state_reg <= S_AND_WAIT;
                S_AND_WAIT: begin
                    if (div_stat.done) begin
                        state_reg <= S_OR_START;
                    end
                end
                S_OR_START: state_reg <= S_OR_WAIT;
                S_OR_WAIT: begin
                    if (div_stat.done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg   <= S_IDLE;
                        and_tp_reg  <= '0;
                        and_fp_reg  <= '0;
                        and_fn_reg  <= '0;
                        or_tp_reg   <= '0;
                        or_fp_reg   <= '0;
                        or_fn_reg   <= '0;
                        total_reg   <= '0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // score and result registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_AND_WAIT && div_stat.done) begin
            and_score_reg <= quotient;
        end
        if (state_reg == S_OR_WAIT && div_stat.done) begin
            or_score_reg <= quotient;
        end
        if (out_load) begin
            m_and_score_reg <= rpf1_pkg::SCORE_W'(and_score_reg);
            m_or_score_reg  <= rpf1_pkg::SCORE_W'(or_score_reg);
            m_samples_reg   <= rpf1_pkg::SAMPLES_W'(total_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_and_score    = m_and_score_reg;
    assign m_or_score     = m_or_score_reg;
    assign m_samples_seen = m_samples_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W + 1)'(and_tp_reg) <= MAX_SUM && (CNT_W + 1)'(or_fp_reg) <= MAX_SUM &&
        (CNT_W + 1)'(total_reg) <= MAX_SUM)
        else $error("counter above saturation bound");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (total_reg == '0 && and_tp_reg == '0 && or_tp_reg == '0 &&
                      m_valid_reg))
        else $error("counters not cleared after result");

    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_and_score <= rpf1_pkg::SCORE_ONE &&
                     m_or_score <= rpf1_pkg::SCORE_ONE))
        else $error("score above one");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_AND_WAIT || state_reg == S_OR_WAIT))
        else $error("divider finished outside a wait state");

    a_div_busy_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == S_AND_WAIT || state_reg == S_OR_WAIT))
        else $error("divider busy outside a wait state");

endmodule

`default_nettype wire
